// ----- design/twiddle_gain_tuner_top_macros.svh -----
// Assertion macros for the twiddle gain tuner checker.
// Each macro expects clk and arst_n in the scope of its use.
`ifndef TWIDDLE_GAIN_TUNER_TOP_MACROS_SVH
`define TWIDDLE_GAIN_TUNER_TOP_MACROS_SVH

// same-cycle implication
`define GTUN_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gtun check failed");

// next-cycle implication
`define GTUN_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gtun check failed");

`endif

// ----- design/gtun_pkg.sv -----
// Shared types and constants for the twiddle gain tuner.
// Used by gtun_step, twiddle_gain_tuner_top and gtun_checker.
package gtun_pkg;

	localparam int GAIN_WIDTH = 32;
	localparam int ERR_WIDTH  = 32;
	localparam int CFG_WIDTH  = 32;
	localparam int IDX_WIDTH  = 2;

	localparam logic [GAIN_WIDTH-1:0] STEP_RESET   = GAIN_WIDTH'(1677722);
	localparam logic [GAIN_WIDTH-1:0] GAIN_ONES    = '1;
	localparam logic [ERR_WIDTH-1:0]  ERR_RESET    = '1;
	localparam int                    RECIP5_SHIFT = GAIN_WIDTH + 2;
	localparam logic [GAIN_WIDTH-1:0] RECIP5       =
		GAIN_WIDTH'(((64'd1 << RECIP5_SHIFT) + 64'd4) / 64'd5);

	localparam logic [IDX_WIDTH-1:0] SEL_P = 2'd0;
	localparam logic [IDX_WIDTH-1:0] SEL_I = 2'd1;
	localparam logic [IDX_WIDTH-1:0] SEL_D = 2'd2;

	localparam logic [IDX_WIDTH-1:0] CFG_STEP_P = 2'd0;
	localparam logic [IDX_WIDTH-1:0] CFG_STEP_I = 2'd1;
	localparam logic [IDX_WIDTH-1:0] CFG_STEP_D = 2'd2;

	typedef enum logic [1:0] {
		PH_RAISE    = 2'd0,
		PH_JUDGE_UP = 2'd1,
		PH_JUDGE_DN = 2'd2
	} gtun_phase_t;

	typedef struct packed {
		logic [GAIN_WIDTH-1:0] gain_p;
		logic [GAIN_WIDTH-1:0] gain_i;
		logic [GAIN_WIDTH-1:0] gain_d;
		logic [ERR_WIDTH-1:0]  run_error;
	} gtun_item_t;

	typedef struct packed {
		logic [GAIN_WIDTH-1:0] next_gain_p;
		logic [GAIN_WIDTH-1:0] next_gain_i;
		logic [GAIN_WIDTH-1:0] next_gain_d;
		logic [IDX_WIDTH-1:0]  tuned_index;
		logic [1:0]            phase_out;
	} gtun_result_t;

	typedef struct packed {
		gtun_phase_t           phase;
		logic [IDX_WIDTH-1:0]  sel;
		logic [ERR_WIDTH-1:0]  best;
		logic [GAIN_WIDTH-1:0] step;
	} gtun_ctx_t;

	typedef struct packed {
		gtun_phase_t           phase;
		logic [IDX_WIDTH-1:0]  sel;
		logic                  best_we;
		logic                  step_we;
		logic [GAIN_WIDTH-1:0] step;
	} gtun_upd_t;

endpackage

// ----- design/gtun_step.sv -----
// One tuning step: gain update, step resize and phase advance for one beat.
// Pure combinational; depends on gtun_pkg.
module gtun_step (
	input  gtun_pkg::gtun_item_t   item,
	input  gtun_pkg::gtun_ctx_t    ctx,
	output gtun_pkg::gtun_result_t res,
	output gtun_pkg::gtun_upd_t    upd
);
	import gtun_pkg::*;

	logic [IDX_WIDTH-1:0]    k;
	logic [GAIN_WIDTH-1:0]   g_sel;
	logic [GAIN_WIDTH-1:0]   s;
	logic [GAIN_WIDTH:0]     add_sum;
	logic [GAIN_WIDTH-1:0]   add_sat;
	logic [GAIN_WIDTH-1:0]   two_s;
	logic [GAIN_WIDTH-1:0]   lower;
	logic [GAIN_WIDTH:0]     grow_sum;
	logic [GAIN_WIDTH-1:0]   grow_s;
	logic [2*GAIN_WIDTH-1:0] prod;
	logic [GAIN_WIDTH-1:0]   quot;
	logic [GAIN_WIDTH-1:0]   five_q;
	logic [2:0]              rem;
	logic [GAIN_WIDTH-1:0]   shrink_s;
	logic                    improve;
	logic                    gain_we;
	logic [GAIN_WIDTH-1:0]   new_gain;
	logic [IDX_WIDTH-1:0]    next_sel;

	always_comb begin
		unique case (ctx.sel)
			SEL_I:   k = SEL_I;
			SEL_D:   k = SEL_D;
			default: k = SEL_P;
		endcase
	end

	always_comb begin
		unique case (k)
			SEL_I:   g_sel = item.gain_i;
			SEL_D:   g_sel = item.gain_d;
			default: g_sel = item.gain_p;
		endcase
	end

	assign s        = ctx.step;
	assign add_sum  = {1'b0, g_sel} + {1'b0, s};
	assign add_sat  = add_sum[GAIN_WIDTH] ? GAIN_ONES : add_sum[GAIN_WIDTH-1:0];
	assign two_s    = s[GAIN_WIDTH-1] ? GAIN_ONES : {s[GAIN_WIDTH-2:0], 1'b0};
	assign lower    = (g_sel > two_s) ? (g_sel - two_s) : '0;
	assign grow_sum = {1'b0, s} + {3'b000, s[GAIN_WIDTH-1:2]};
	assign grow_s   = grow_sum[GAIN_WIDTH] ? GAIN_ONES : grow_sum[GAIN_WIDTH-1:0];

	assign prod     = s * RECIP5;
	assign quot     = GAIN_WIDTH'(prod >> RECIP5_SHIFT);
	assign five_q   = quot + {quot[GAIN_WIDTH-3:0], 2'b00};
	assign rem      = 3'(s - five_q);
	assign shrink_s = {quot[GAIN_WIDTH-3:0], 2'b00}
		+ GAIN_WIDTH'((rem == 3'd0) ? 3'd0 : (rem - 3'd1));

	assign improve  = item.run_error < ctx.best;
	assign next_sel = (k == SEL_D) ? SEL_P : (k + 2'd1);

	always_comb begin
		gain_we      = 1'b0;
		new_gain     = add_sat;
		upd.phase    = PH_JUDGE_UP;
		upd.sel      = k;
		upd.best_we  = 1'b0;
		upd.step_we  = 1'b0;
		upd.step     = grow_s;
		unique case (ctx.phase)
			PH_JUDGE_UP: begin
				if (improve) begin
					upd.best_we = 1'b1;
					upd.step_we = 1'b1;
					upd.phase   = PH_RAISE;
					upd.sel     = next_sel;
				end else begin
					gain_we   = 1'b1;
					new_gain  = lower;
					upd.phase = PH_JUDGE_DN;
				end
			end
			PH_JUDGE_DN: begin
				upd.step_we = 1'b1;
				upd.phase   = PH_RAISE;
				upd.sel     = next_sel;
				if (improve) begin
					upd.best_we = 1'b1;
				end else begin
					gain_we  = 1'b1;
					upd.step = shrink_s;
				end
			end
			default: begin
				gain_we = 1'b1;
			end
		endcase
	end

	always_comb begin
		res.next_gain_p = (gain_we && k == SEL_P) ? new_gain : item.gain_p;
		res.next_gain_i = (gain_we && k == SEL_I) ? new_gain : item.gain_i;
		res.next_gain_d = (gain_we && k == SEL_D) ? new_gain : item.gain_d;
		res.tuned_index = upd.sel;
		res.phase_out   = upd.phase;
	end

endmodule

// ----- design/twiddle_gain_tuner_top.sv -----
// Twiddle gain tuner top level: input register, step logic, result register.
// Throughput: one item per cycle while the result side does not stall; the loop is
// the tuner state updated by gtun_step. Items pass the input, then result register.
// Reset: phase to raise, proportional gain selected, best error all ones,
// all three steps to 1677722 (about 0.1 in Q8.24). Depends on gtun_pkg, gtun_step.
module twiddle_gain_tuner_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  gtun_pkg::gtun_item_t                 item,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output gtun_pkg::gtun_result_t               result,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [gtun_pkg::IDX_WIDTH-1:0]       cfg_index,
	input  logic [gtun_pkg::CFG_WIDTH-1:0]       cfg_data
);
	import gtun_pkg::*;

	gtun_item_t            item_s1;
	logic                  valid_s1;
	logic                  adv;
	logic                  accept;
	gtun_phase_t           phase_q;
	logic [IDX_WIDTH-1:0]  sel_q;
	logic [ERR_WIDTH-1:0]  best_q;
	logic [GAIN_WIDTH-1:0] step_q [3];
	gtun_ctx_t             ctx;
	gtun_upd_t             upd;
	gtun_result_t          res;
	logic [GAIN_WIDTH-1:0] cfg_step;

	assign cfg_ready  = !valid_s1;
	assign cfg_step   = GAIN_WIDTH'(cfg_data);
	assign adv        = valid_s1 && !(result_valid && result_stall);
	assign item_stall = valid_s1 && result_valid && result_stall;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	always_comb begin
		ctx.phase = phase_q;
		ctx.sel   = sel_q;
		ctx.best  = best_q;
		unique case (sel_q)
			SEL_I:   ctx.step = step_q[1];
			SEL_D:   ctx.step = step_q[2];
			default: ctx.step = step_q[0];
		endcase
	end

	gtun_step u_step (
		.item (item_s1),
		.ctx  (ctx),
		.res  (res),
		.upd  (upd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RAISE;
			sel_q   <= SEL_P;
			best_q  <= ERR_RESET;
		end else if (adv) begin
			phase_q <= upd.phase;
			sel_q   <= upd.sel;
			if (upd.best_we) begin
				best_q <= item_s1.run_error;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q[0] <= STEP_RESET;
			step_q[1] <= STEP_RESET;
			step_q[2] <= STEP_RESET;
		end else if (adv) begin
			if (upd.step_we) begin
				unique case (sel_q)
					SEL_I:   step_q[1] <= upd.step;
					SEL_D:   step_q[2] <= upd.step;
					default: step_q[0] <= upd.step;
				endcase
			end
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_STEP_P: step_q[0] <= cfg_step;
				CFG_STEP_I: step_q[1] <= cfg_step;
				CFG_STEP_D: step_q[2] <= cfg_step;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result <= res;
		end
	end

endmodule

// ----- design/gtun_checker.sv -----
// Port-level checks for twiddle_gain_tuner_top, attached by bind.
// Depends on gtun_pkg and twiddle_gain_tuner_top_macros.svh.
`include "twiddle_gain_tuner_top_macros.svh"

module gtun_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   result_valid,
	input logic                   result_stall,
	input gtun_pkg::gtun_result_t result
);
	import gtun_pkg::*;

	logic [1:0] last_phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_phase_q <= PH_RAISE;
		end else if (result_valid && !result_stall) begin
			last_phase_q <= result.phase_out;
		end
	end

	`GTUN_ASSERT_NEXT(a_valid_hold, result_valid && result_stall, result_valid)
	`GTUN_ASSERT_NEXT(a_beat_hold, result_valid && result_stall, $stable(result))
	`GTUN_ASSERT_SAME(a_after_raise, result_valid && last_phase_q == PH_RAISE, result.phase_out == PH_JUDGE_UP)
	`GTUN_ASSERT_SAME(a_after_lower, result_valid && last_phase_q == PH_JUDGE_DN, result.phase_out == PH_RAISE)

endmodule

bind twiddle_gain_tuner_top gtun_checker u_gtun_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
